// ===== src/swpl_pkg.sv =====
// Shared types and constants for the sine-to-PWM-level synthesizer.
// Holds the CORDIC datapath struct, fixed-point widths and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swpl_pkg;

  // Q1.30 x/y with headroom, Q0.32 turn angle with one guard bit
  localparam int XY_W = 34;
  localparam int Z_W  = 33;
  localparam int AMP_W = 16;
  localparam int PROD_W = XY_W + AMP_W;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);
  localparam logic signed [Z_W-1:0] TURN_HALF = 33'sh0_8000_0000;
  localparam logic signed [Z_W-1:0] TURN_QTR  = 33'sh0_4000_0000;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] REG_START_PHASE  = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE    = 2'd2;
  localparam logic [1:0] REG_LEVEL_OFFSET = 2'd3;

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] wave;
    logic [7:0]         pwm;
  } level_t;

  // round(atan(2^-i) / (2*pi) * 2^32)
  function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      0:  r = 33'sd536870912;
      1:  r = 33'sd316933406;
      2:  r = 33'sd167458907;
      3:  r = 33'sd85004756;
      4:  r = 33'sd42667331;
      5:  r = 33'sd21354465;
      6:  r = 33'sd10679838;
      7:  r = 33'sd5340245;
      8:  r = 33'sd2670163;
      9:  r = 33'sd1335087;
      10: r = 33'sd667544;
      11: r = 33'sd333772;
      12: r = 33'sd166886;
      13: r = 33'sd83443;
      14: r = 33'sd41722;
      15: r = 33'sd20861;
      16: r = 33'sd10430;
      17: r = 33'sd5215;
      18: r = 33'sd2608;
      19: r = 33'sd1304;
      20: r = 33'sd652;
      21: r = 33'sd326;
      22: r = 33'sd163;
      23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/swpl_phase_gen.sv =====
// Phase accumulator front end: phase = start + step * time, folded to +-1/4 turn.
// Two register stages; feeds the first CORDIC cell. Depends on swpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpl_phase_gen (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [31:0]       time_us,
  input  wire logic [31:0]       phase_step,
  input  wire logic [31:0]       start_phase,
  output swpl_pkg::cordic_t      seed
);
  import swpl_pkg::*;

  logic        mul_valid;
  logic [31:0] mul_prod;
  logic [31:0] phase;
  logic signed [Z_W-1:0] angle;
  logic signed [Z_W-1:0] folded;
  cordic_t     seed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
    end
  end

  // only the low 32 bits matter: phase wraps modulo one turn
  always_ff @(posedge clk) begin
    if (en) begin
      mul_prod <= 32'(phase_step * time_us);
    end
  end

  always_comb begin
    phase  = start_phase + mul_prod;
    angle  = {phase[31], phase};
    // sin(1/2 - a) = sin(a)
    if (angle > TURN_QTR) begin
      folded = TURN_HALF - angle;
    end else if (angle < -TURN_QTR) begin
      folded = -TURN_HALF - angle;
    end else begin
      folded = angle;
    end
    seed_next.valid = mul_valid;
    seed_next.x     = CORDIC_X0;
    seed_next.y     = '0;
    seed_next.z     = folded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed.valid <= 1'b0;
    end else if (en) begin
      seed.valid <= seed_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seed.x <= seed_next.x;
      seed.y <= seed_next.y;
      seed.z <= seed_next.z;
    end
  end

endmodule

`default_nettype wire

// ===== src/swpl_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its own pipeline register.
// Shift amount and arctangent are fixed by STAGE. Depends on swpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpl_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  swpl_pkg::cordic_t  din,
  output swpl_pkg::cordic_t  dout
);
  import swpl_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_turn(STAGE);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  cordic_t                dout_next;

  always_comb begin
    dx = din.y >>> STAGE;
    dy = din.x >>> STAGE;
    dout_next.valid = din.valid;
    if (!din.z[Z_W-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - ATAN;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= dout_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.x <= dout_next.x;
      dout.y <= dout_next.y;
      dout.z <= dout_next.z;
    end
  end

endmodule

`default_nettype wire

// ===== src/swpl_level_out.sv =====
// Scales the CORDIC sine by amplitude (registered product), then rounds,
// adds the offset, saturates to Q2.14 and derives the PWM byte. Depends on swpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpl_level_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  swpl_pkg::cordic_t       sine,
  input  wire logic signed [15:0] amplitude,
  input  wire logic signed [15:0] level_offset,
  output swpl_pkg::level_t        res
);
  import swpl_pkg::*;

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [19:0]       scaled;
  logic signed [20:0]       sum;
  logic signed [15:0]       wave;
  logic signed [16:0]       biased;
  logic signed [25:0]       duty;
  logic [10:0]              duty_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= sine.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(amplitude) * PROD_W'(sine.y);
    end
  end

  always_comb begin
    // Q3.44 -> Q2.14, round half up
    rounded = prod + (PROD_W'(1) <<< 29);
    scaled  = rounded[49:30];
    sum     = 21'(scaled) + 21'(level_offset);
    if (sum > 21'sd32767) begin
      wave = 16'sh7FFF;
    end else if (sum < -21'sd32768) begin
      wave = 16'sh8000;
    end else begin
      wave = sum[15:0];
    end
    // (w + 1.0) * 255 / 2 in Q15, truncated
    biased = 17'(wave) + 17'sd16384;
    duty   = (26'(biased) <<< 8) - 26'(biased);
    duty_q = duty[25:15];
    res.valid = prod_valid;
    res.wave  = wave;
    if (duty[25]) begin
      res.pwm = 8'd0;
    end else if (duty_q > 11'd255) begin
      res.pwm = 8'd255;
    end else begin
      res.pwm = duty_q[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/sine_wave_to_pwm_level.sv =====
// Sine wave to PWM level: DDS phase, pipelined CORDIC sine, amplitude/offset scaling.
// Throughput: one time stamp per cycle except while in_stall is high; the chain of
// CORDIC cells and the phase/scale stages all advance together, with a one-entry skid
// at the output that freezes them all while it is occupied.
// Reset clears all valid bits and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module sine_wave_to_pwm_level #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [31:0]        time_us,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic signed [15:0] wave_value,
  output      logic [7:0]         pwm_level,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import swpl_pkg::*;

  localparam int NUM_CELLS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic [31:0]        phase_step;
  logic [31:0]        start_phase;
  logic signed [15:0] amplitude;
  logic signed [15:0] level_offset;

  logic               en;
  cordic_t            chain [NUM_CELLS+1];
  level_t             res;

  logic               skid_valid;
  logic signed [15:0] skid_wave;
  logic [7:0]         skid_pwm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= 32'd42950;
      start_phase  <= 32'd170891318;
      amplitude    <= 16'sd16384;
      level_offset <= 16'sd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_START_PHASE:  start_phase  <= cfg_data;
        REG_AMPLITUDE:    amplitude    <= cfg_data[15:0];
        REG_LEVEL_OFFSET: level_offset <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline freezes only while the skid entry is occupied
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  swpl_phase_gen u_phase (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .time_us     (time_us),
    .phase_step  (phase_step),
    .start_phase (start_phase),
    .seed        (chain[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    swpl_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  swpl_level_out u_level (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .sine         (chain[NUM_CELLS]),
    .amplitude    (amplitude),
    .level_offset (level_offset),
    .res          (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (res.valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid  <= skid_valid | res.valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (!skid_valid) begin
        skid_wave <= res.wave;
        skid_pwm  <= res.pwm;
      end
    end else if (skid_valid) begin
      wave_value <= skid_wave;
      pwm_level  <= skid_pwm;
    end else begin
      wave_value <= res.wave;
      pwm_level  <= res.pwm;
    end
  end

  // skid entry is only ever filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied with empty output register");

  // a taken output drains the skid entry in the next cycle
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (!skid_valid && out_valid))
    else $error("skid entry did not drain");

  a_pwm_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wave_value <= -16'sd16384) |-> (pwm_level == 8'd0))
    else $error("pwm level not zero at bottom of range");

  a_pwm_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wave_value >= 16'sd16384) |-> (pwm_level == 8'd255))
    else $error("pwm level not full at top of range");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for sine_wave_to_pwm_level: a directed table, then random phases.
// Expected samples come from a behavioral DDS/CORDIC predictor kept inside this file, or from typed table levels.
// Depends on swpl_pkg (register indexes) and the top module sine_wave_to_pwm_level.
`timescale 1ns / 1ps

module tb;

  localparam int STAGES = 16;
  localparam int N_DIR = 24;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 240;

  // round(atan(2^-i) / (2*pi) * 2^32)
  localparam longint ATAN_TURNS [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [15:0] wave;
    logic [7:0]         pwm;
  } level_t;

  typedef struct packed {
    logic [31:0] step;
    logic [31:0] start;
    logic [15:0] amp;
    logic [15:0] ofs;
  } synth_cfg_t;

  typedef struct packed {
    synth_cfg_t  cfg;
    logic [31:0] t;
    logic        typed;
    level_t      lvl;
  } dir_row_t;

  localparam synth_cfg_t RESET_CFG = '{32'd42950, 32'd170891318, 16'h4000, 16'h0000};

  // Typed levels only where the answer is obvious: zero amplitude, hard saturation.
  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    '{RESET_CFG, 32'h0000_0000, 1'b0, '{16'h0000, 8'h00}},
    '{RESET_CFG, 32'hFFFF_FFFF, 1'b0, '{16'h0000, 8'h00}},
    '{RESET_CFG, 32'd1000000, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h0000_0000, 16'h4000, 16'h0000}, 32'hA5A5_A5A5, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h4000_0000, 16'h7FFF, 16'h7FFF}, 32'h5A5A_5A5A, 1'b1, '{16'h7FFF, 8'hFF}},
    '{'{32'h0, 32'hC000_0000, 16'h7FFF, 16'h8000}, 32'h0000_0000, 1'b1, '{16'h8000, 8'h00}},
    '{'{32'h0, 32'h8000_0000, 16'h4000, 16'h0000}, 32'h1234_5678, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h8000_0001, 16'h4000, 16'h0000}, 32'hEDCB_A987, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h7FFF_FFFF, 16'h4000, 16'h0000}, 32'h0F0F_0F0F, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h4000_0001, 16'h4000, 16'h0000}, 32'hF0F0_F0F0, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'hBFFF_FFFF, 16'h4000, 16'h0000}, 32'h3333_3333, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h4000_0000, 16'h8000, 16'h0000}, 32'hCCCC_CCCC, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h0, 32'h4000_0000, 16'h8000, 16'h8000}, 32'h0000_0001, 1'b1, '{16'h8000, 8'h00}},
    '{'{32'h0, 32'hC000_0000, 16'h8000, 16'h7FFF}, 32'h8000_0000, 1'b1, '{16'h7FFF, 8'hFF}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000}, 32'hFFFF_FFFF, 1'b1,
      '{16'h0000, 8'h7F}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h7FFF}, 32'h7FFF_FFFF, 1'b1,
      '{16'h7FFF, 8'hFF}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h8000}, 32'h5555_5555, 1'b1,
      '{16'h8000, 8'h00}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'hC000}, 32'hAAAA_AAAA, 1'b1,
      '{16'hC000, 8'h00}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'hBFFF}, 32'h0000_0002, 1'b1,
      '{16'hBFFF, 8'h00}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h4000}, 32'h0000_0003, 1'b1,
      '{16'h4000, 8'hFF}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h3FFF}, 32'h0000_0004, 1'b1,
      '{16'h3FFF, 8'hFE}},
    '{'{32'h0000_0001, 32'h0, 16'h4000, 16'h0000}, 32'hFFFF_FFFF, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'hFFFF_FFFF, 32'h0, 16'h4000, 16'h0000}, 32'h0000_0001, 1'b0, '{16'h0000, 8'h00}},
    '{'{32'h8000_0000, 32'h0, 16'h4000, 16'h0000}, 32'h0000_0001, 1'b0, '{16'h0000, 8'h00}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        time_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] wave_value;
  logic [7:0]         pwm_level;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = swpl_pkg::REG_PHASE_STEP;
  logic [31:0]        cfg_data = '0;

  // typed expectation travels with the payload it belongs to
  logic   fixed_on = 1'b0;
  level_t fixed_lvl = '0;

  synth_cfg_t shadow_cfg = RESET_CFG;
  synth_cfg_t drive_cfg = RESET_CFG;
  level_t     level_q [$];
  int         fail_cnt = 0;
  int         shown = 0;
  bit         no_gaps = 1'b0;
  int         stall_left = 0;

  sine_wave_to_pwm_level #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .time_us    (time_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .wave_value (wave_value),
    .pwm_level  (pwm_level),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // DDS phase, fold to [-1/4, 1/4] turn, rotation-mode CORDIC, scale, saturate, duty byte
  function automatic level_t sine_level(input logic [31:0] t);
    logic [31:0] ph;
    longint      ang, x, y, z, dx, dy, w, p;
    level_t      r;
    ph = shadow_cfg.start + shadow_cfg.step * t;
    ang = longint'(signed'(ph));
    if (ang > 64'sd1073741824)
      ang = 64'sd2147483648 - ang;
    else if (ang < -64'sd1073741824)
      ang = -64'sd2147483648 - ang;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    w = (longint'(signed'(shadow_cfg.amp)) * y + (64'sd1 <<< 29)) >>> 30;
    w = w + longint'(signed'(shadow_cfg.ofs));
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    p = (w + 16384) * 255;
    if (p < 0)
      p = 0;
    else begin
      p = p >>> 15;
      if (p > 255) p = 255;
    end
    r.wave = w[15:0];
    r.pwm = p[7:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic synth_cfg_t pick_cfg();
    synth_cfg_t c;
    case ($urandom_range(0, 4))
      0: c.step = '0;
      1: c.step = '1;
      2: c.step = $urandom_range(1, 65536);
      default: c.step = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: c.start = '0;
      1: c.start = '1;
      default: c.start = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0: c.amp = 16'h8000;
      1: c.amp = 16'h7FFF;
      2: c.amp = '0;
      default: c.amp = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: c.ofs = 16'h8000;
      1: c.ofs = 16'h7FFF;
      2: c.ofs = 16'($urandom_range(0, 4095)) - 16'd2048;
      default: c.ofs = 16'($urandom);
    endcase
    return c;
  endfunction

  // one transfer on the input channel; returns at the edge that takes it
  task automatic send_time(input logic [31:0] t, input logic typed, input level_t lvl);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_us <= t;
    fixed_on <= typed;
    fixed_lvl <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // drain the pipeline, then load all four registers back to back
  task automatic apply_cfg(input synth_cfg_t c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= swpl_pkg::REG_PHASE_STEP;
    cfg_data <= c.step;
    @(posedge clk);
    cfg_index <= swpl_pkg::REG_START_PHASE;
    cfg_data <= c.start;
    @(posedge clk);
    cfg_index <= swpl_pkg::REG_AMPLITUDE;
    cfg_data <= {16'($urandom), c.amp};
    @(posedge clk);
    cfg_index <= swpl_pkg::REG_LEVEL_OFFSET;
    cfg_data <= {16'($urandom), c.ofs};
    @(posedge clk);
    cfg_write <= 1'b0;
    drive_cfg = c;
  endtask

  // output side: runs of stall and of no stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!no_gaps && $urandom_range(0, 1)) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end
  end

  // scoreboard: check output transfers, queue predictions, track register writes
  always @(posedge clk) begin
    level_t got, want;
    if (rst) begin
      level_q.delete();
      shadow_cfg = RESET_CFG;
    end else begin
      if (out_valid && !out_stall) begin
        got.wave = wave_value;
        got.pwm = pwm_level;
        if (level_q.size() == 0) begin
          fail_cnt++;
          if (shown < 10)
            $display("%0t: unexpected sample wave=%0d pwm=%0d", $realtime, got.wave, got.pwm);
          shown++;
        end else begin
          want = level_q.pop_front();
          if (got.wave !== want.wave || got.pwm !== want.pwm) begin
            fail_cnt++;
            if (shown < 10)
              $display("%0t: mismatch wave exp %0d got %0d, pwm exp %0d got %0d",
                       $realtime, want.wave, got.wave, want.pwm, got.pwm);
            shown++;
          end
        end
      end
      if (in_valid && !in_stall)
        level_q.push_back(fixed_on ? fixed_lvl : sine_level(time_us));
      if (cfg_write) begin
        case (cfg_index)
          swpl_pkg::REG_PHASE_STEP:   shadow_cfg.step = cfg_data;
          swpl_pkg::REG_START_PHASE:  shadow_cfg.start = cfg_data;
          swpl_pkg::REG_AMPLITUDE:    shadow_cfg.amp = cfg_data[15:0];
          swpl_pkg::REG_LEVEL_OFFSET: shadow_cfg.ofs = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    dir_row_t    row;
    logic [31:0] base, inc;
    int          n, run;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIR; k++) begin
      row = DIR_TAB[k];
      if (row.cfg != drive_cfg)
        apply_cfg(row.cfg);
      send_time(row.t, row.typed, row.lvl);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_cfg(pick_cfg());
      no_gaps = (ph % 4 == 3);
      n = 0;
      // runs of evenly spaced time stamps, as a sample clock would give, plus stray ones
      while (n < PHASE_ITEMS) begin
        run = $urandom_range(1, 40);
        base = $urandom;
        case ($urandom_range(0, 3))
          0: inc = 32'd1;
          1: inc = $urandom_range(2, 1000);
          2: inc = $urandom;
          default: begin
            base = 32'hFFFF_FFFF - $urandom_range(0, 20);
            inc = 32'd1;
          end
        endcase
        for (int j = 0; j < run && n < PHASE_ITEMS; j++) begin
          send_time(base, 1'b0, '0);
          base = base + inc;
          n++;
        end
      end
    end

    in_valid <= 1'b0;
    no_gaps = 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (STAGES + 8) @(posedge clk);
    if (fail_cnt == 0 && level_q.size() == 0)
      $display("PASS sine_wave_to_pwm_level");
    else
      $display("FAIL sine_wave_to_pwm_level");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL sine_wave_to_pwm_level");
    $finish;
  end

endmodule
